>>> rtl/tdr_pkg.sv
`timescale 1ns / 1ps

package tdr_pkg;

	// Tile geometry and frame limits.
	localparam int unsigned TILE_SIZE     = 16;
	localparam int unsigned TILE_SHIFT    = $clog2(TILE_SIZE);
	localparam int unsigned MAX_TILE_ROWS = 1024;
	localparam int unsigned MAX_DIM       = 16384;
	localparam int unsigned HEIGHT_LIM    = (MAX_TILE_ROWS * TILE_SIZE < MAX_DIM) ?
		MAX_TILE_ROWS * TILE_SIZE : MAX_DIM;

	// Widths: a position counter, a frame dimension, a tile index and a pixel.
	localparam int unsigned POS_W  = 14;
	localparam int unsigned DIM_W  = 15;
	localparam int unsigned TIDX_W = POS_W - TILE_SHIFT;
	localparam int unsigned PIX_W  = 32;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic [PIX_W-1:0] old_pixel;
		logic [PIX_W-1:0] new_pixel;
	} in_item_t;

	typedef struct packed {
		logic             changed;
		logic [DIM_W-1:0] rect_left;
		logic [DIM_W-1:0] rect_top;
		logic [DIM_W-1:0] rect_right;
		logic [DIM_W-1:0] rect_bottom;
	} out_item_t;

	// A zero register value counts as one, anything above the limit as the limit.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] value,
			input logic [DIM_W-1:0] limit);
		logic [DIM_W-1:0] res;
		res = value;
		if (res == '0) begin
			res = DIM_W'(1);
		end
		if (res > limit) begin
			res = limit;
		end
		return res;
	endfunction

endpackage

>>> rtl/tdr_tracker.sv
`timescale 1ns / 1ps

module tdr_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  tdr_pkg::in_item_t                   in_item,
	input  logic                                cfg_we,
	input  logic [tdr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tdr_pkg::DIM_W-1:0]           cfg_wdata,
	output logic                                res_valid,
	output tdr_pkg::out_item_t                  res_item
);

	localparam logic [tdr_pkg::DIM_W-1:0] WIDTH_LIM  = tdr_pkg::DIM_W'(tdr_pkg::MAX_DIM);
	localparam logic [tdr_pkg::DIM_W-1:0] HEIGHT_LIM = tdr_pkg::DIM_W'(tdr_pkg::HEIGHT_LIM);

	logic [tdr_pkg::DIM_W-1:0]  width_q, height_q;
	logic [tdr_pkg::POS_W-1:0]  col_q, row_q;
	logic [tdr_pkg::TIDX_W-1:0] min_col_q, max_col_q, min_row_q, max_row_q;
	logic                       any_q;

	logic [tdr_pkg::TIDX_W-1:0] tile_col, tile_row;
	logic [tdr_pkg::TIDX_W-1:0] nxt_min_col, nxt_max_col, nxt_min_row, nxt_max_row;
	logic                       nxt_any;
	logic                       pixel_diff, last_col, last_row, frame_end;
	logic [tdr_pkg::DIM_W-1:0]  right_raw, bottom_raw;

	assign tile_col   = col_q[tdr_pkg::POS_W-1:tdr_pkg::TILE_SHIFT];
	assign tile_row   = row_q[tdr_pkg::POS_W-1:tdr_pkg::TILE_SHIFT];
	assign pixel_diff = in_item.old_pixel != in_item.new_pixel;

	// The pixel that ends a row or the frame.
	assign last_col  = ({1'b0, col_q} + tdr_pkg::DIM_W'(1)) >= width_q;
	assign last_row  = ({1'b0, row_q} + tdr_pkg::DIM_W'(1)) >= height_q;
	assign frame_end = last_col && last_row;

	// Bounding box including the current pixel.
	always_comb begin
		nxt_min_col = min_col_q;
		nxt_max_col = max_col_q;
		nxt_min_row = min_row_q;
		nxt_max_row = max_row_q;
		if (pixel_diff && !any_q) begin
			nxt_min_col = tile_col;
			nxt_max_col = tile_col;
			nxt_min_row = tile_row;
			nxt_max_row = tile_row;
		end else if (pixel_diff) begin
			if (tile_col < min_col_q) nxt_min_col = tile_col;
			if (tile_col > max_col_q) nxt_max_col = tile_col;
			if (tile_row < min_row_q) nxt_min_row = tile_row;
			if (tile_row > max_row_q) nxt_max_row = tile_row;
		end
	end
	assign nxt_any = any_q || pixel_diff;

	// Rectangle in pixels; the exclusive edges are clipped to the frame.
	assign right_raw  = {({1'b0, nxt_max_col} + (tdr_pkg::TIDX_W + 1)'(1)),
		{tdr_pkg::TILE_SHIFT{1'b0}}};
	assign bottom_raw = {({1'b0, nxt_max_row} + (tdr_pkg::TIDX_W + 1)'(1)),
		{tdr_pkg::TILE_SHIFT{1'b0}}};

	always_comb begin
		res_item = '0;
		if (nxt_any) begin
			res_item.changed     = 1'b1;
			res_item.rect_left   = {1'b0, nxt_min_col, {tdr_pkg::TILE_SHIFT{1'b0}}};
			res_item.rect_top    = {1'b0, nxt_min_row, {tdr_pkg::TILE_SHIFT{1'b0}}};
			res_item.rect_right  = (right_raw > width_q) ? width_q : right_raw;
			res_item.rect_bottom = (bottom_raw > height_q) ? height_q : bottom_raw;
		end
	end
	assign res_valid = accept && frame_end;

	// Frame state: a register write or the end of a frame restarts it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= tdr_pkg::DIM_W'(1);
			height_q  <= tdr_pkg::DIM_W'(1);
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= '0;
			max_col_q <= '0;
			min_row_q <= '0;
			max_row_q <= '0;
			any_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tdr_pkg::REG_FRAME_WIDTH: begin
					width_q <= tdr_pkg::eff_dim(cfg_wdata, WIDTH_LIM);
				end
				tdr_pkg::REG_FRAME_HEIGHT: begin
					height_q <= tdr_pkg::eff_dim(cfg_wdata, HEIGHT_LIM);
				end
				default: begin
				end
			endcase
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= '0;
			max_col_q <= '0;
			min_row_q <= '0;
			max_row_q <= '0;
			any_q     <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				col_q     <= '0;
				row_q     <= '0;
				min_col_q <= '0;
				max_col_q <= '0;
				min_row_q <= '0;
				max_row_q <= '0;
				any_q     <= 1'b0;
			end else begin
				min_col_q <= nxt_min_col;
				max_col_q <= nxt_max_col;
				min_row_q <= nxt_min_row;
				max_row_q <= nxt_max_row;
				any_q     <= nxt_any;
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + tdr_pkg::POS_W'(1);
				end else begin
					col_q <= col_q + tdr_pkg::POS_W'(1);
				end
			end
		end
	end

endmodule

>>> rtl/tdr_out_buf.sv
`timescale 1ns / 1ps

module tdr_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tdr_pkg::out_item_t push_item,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output tdr_pkg::out_item_t out_data
);

	logic               out_valid_q, skid_valid_q;
	tdr_pkg::out_item_t out_data_q, skid_data_q;
	logic               pop;

	assign pop       = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign full      = skid_valid_q;

	// Control: the output register refills from the skid stage first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves with the control above.
	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				if (push) begin
					skid_data_q <= push_item;
				end
			end else if (push) begin
				out_data_q <= push_item;
			end
		end else if (push) begin
			skid_data_q <= push_item;
		end
	end

endmodule

>>> rtl/tile_dirty_rect_detect_core.sv
`timescale 1ns / 1ps

// Tile dirty rectangle detector.
// The input channel (in_valid, in_stall, in_data) carries pairs of old and new
// pixels in raster order; the block counts column and row itself, using the
// frame_width and frame_height registers. Every 16x16 tile holding a differing
// pixel widens a bounding box. The last pixel of a frame produces one request
// on the output channel (out_valid, out_stall, out_data): the changed flag and
// the rectangle in pixels, all zero when nothing changed. Other pixels produce
// nothing.
// Throughput is one pixel pair per cycle while in_stall is low; the result
// request is registered in the output buffer. The per-pixel compare and min/max
// update sit between the frame state registers and a two-entry output buffer.
// A stalled result waits in the buffer while pixels keep flowing; in_stall
// rises only when both buffer entries are full.
// Reset sets both dimensions to 1 and clears position and box. A register write
// through cfg_we, cfg_index and cfg_wdata also restarts the frame.
module tile_dirty_rect_detect_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  tdr_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output tdr_pkg::out_item_t            out_data,
	input  logic                          cfg_we,
	input  logic [tdr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tdr_pkg::DIM_W-1:0]     cfg_wdata
);

	logic               accept, res_valid, buf_full;
	tdr_pkg::out_item_t res_item;

	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	tdr_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_item   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	tdr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_item (res_item),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

>>> rtl/tdr_checker.sv
`timescale 1ns / 1ps

module tdr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input tdr_pkg::out_item_t out_data
);

	// A stalled result request holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result request changed");

	// An unchanged frame reports an empty rectangle.
	a_clean_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.changed |-> out_data.rect_left == '0 &&
			out_data.rect_top == '0 && out_data.rect_right == '0 &&
			out_data.rect_bottom == '0)
		else $error("unchanged frame with nonzero rectangle");

	// A dirty rectangle is never empty and starts on a tile boundary.
	a_rect_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.changed |-> out_data.rect_left < out_data.rect_right &&
			out_data.rect_top < out_data.rect_bottom &&
			out_data.rect_left[tdr_pkg::TILE_SHIFT-1:0] == '0 &&
			out_data.rect_top[tdr_pkg::TILE_SHIFT-1:0] == '0)
		else $error("malformed dirty rectangle");

	// Input stalls only while a result request is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

endmodule

bind tile_dirty_rect_detect_core tdr_checker u_tdr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
